// ===== sv/charlieplexed_soc_display_driver_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the state-of-charge display driver
// Immediate-implication and next-cycle property checks used by the top level.
// ----------------------------------------------------------------------------
`ifndef CHARLIEPLEXED_SOC_DISPLAY_DRIVER_ASSERT_SVH
`define CHARLIEPLEXED_SOC_DISPLAY_DRIVER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CSDD_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("display driver check failed");

// Consequent must hold in the cycle after the antecedent.
`define CSDD_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("display driver sequencing check failed");

`endif

// ===== sv/csdd_pkg.sv =====
// ----------------------------------------------------------------------------
// csdd_pkg
// Widths, codes and seven-segment helpers for the state-of-charge display.
// ----------------------------------------------------------------------------
package csdd_pkg;

    localparam int SOC_W    = 10;
    localparam int CUR_W    = 16;
    localparam int FLAG_W   = 16;
    localparam int FLAG_IDX_W = $clog2(FLAG_W);
    localparam int PIN_W    = 5;
    localparam int PHASE_W  = 3;
    localparam int PCT_W    = 7;
    localparam int S_DATA_W = ((SOC_W + CUR_W + FLAG_W + 7) / 8) * 8;
    localparam int M_DATA_W = ((PIN_W + PIN_W + PHASE_W + 7) / 8) * 8;

    // word kinds carried on tuser
    localparam logic FUNC_READING = 1'b0;
    localparam logic FUNC_TICK    = 1'b1;

    // scan phases
    localparam logic [PHASE_W-1:0] PHASE_0 = 3'd0;
    localparam logic [PHASE_W-1:0] PHASE_1 = 3'd1;
    localparam logic [PHASE_W-1:0] PHASE_2 = 3'd2;
    localparam logic [PHASE_W-1:0] PHASE_3 = 3'd3;
    localparam logic [PHASE_W-1:0] PHASE_4 = 3'd4;

    // x / 10 == (x * 205) >> 11 for every x below 1029
    localparam int RECIP_10    = 205;
    localparam int RECIP_SHIFT = 11;
    localparam int RECIP_W     = 8;
    localparam int PROD_W      = SOC_W + RECIP_W;

    // charging threshold in centiamps
    localparam logic signed [CUR_W-1:0] CHARGE_LIMIT = -16'sd100;

    // segment bit positions
    localparam int SEG_A = 0;
    localparam int SEG_B = 1;
    localparam int SEG_C = 2;
    localparam int SEG_D = 3;
    localparam int SEG_E = 4;
    localparam int SEG_F = 5;
    localparam int SEG_G = 6;

    localparam logic [3:0] DIGIT_E = 4'hE;

    typedef logic [7:0] seg_t;

    function automatic seg_t glyph(input logic [3:0] digit);
        seg_t seg;
        unique case (digit)
            4'h0: seg = 8'h3F;
            4'h1: seg = 8'h06;
            4'h2: seg = 8'h5B;
            4'h3: seg = 8'h4F;
            4'h4: seg = 8'h66;
            4'h5: seg = 8'h6D;
            4'h6: seg = 8'h7D;
            4'h7: seg = 8'h07;
            4'h8: seg = 8'h7F;
            4'h9: seg = 8'h6F;
            4'hA: seg = 8'h77;
            4'hB: seg = 8'h7C;
            4'hC: seg = 8'h58;
            4'hD: seg = 8'h5E;
            4'hE: seg = 8'h79;
            4'hF: seg = 8'h71;
            default: seg = 8'h00;
        endcase
        return seg;
    endfunction

    // tens digit of a value below 100, by threshold compare
    function automatic logic [3:0] tens_of(input logic [PCT_W-1:0] val);
        logic [3:0] tens;
        tens = 4'd0;
        for (int k = 1; k < 10; k++) begin
            if (val >= PCT_W'(10 * k)) begin
                tens = 4'(k);
            end
        end
        return tens;
    endfunction

    // index of the highest set flag
    function automatic logic [FLAG_IDX_W-1:0] top_flag(input logic [FLAG_W-1:0] flags);
        logic [FLAG_IDX_W-1:0] idx;
        idx = '0;
        for (int b = 0; b < FLAG_W; b++) begin
            if (flags[b]) begin
                idx = FLAG_IDX_W'(b);
            end
        end
        return idx;
    endfunction

endpackage

// ===== sv/charlieplexed_soc_display_driver.sv =====
// Datapath: a scan tick word passes the input register, then the result register, before its pin word shows on m_tdata.
// Throughput: one word per cycle; the input register drains whenever the result
// register is free or being taken, and reading words never wait on the output.
// Reset (aresetn low, synchronous): all digits blank, scan phase 0, both registers empty.
// ----------------------------------------------------------------------------
// charlieplexed_soc_display_driver
// Three-digit state-of-charge display plus two indicators on five
// charlieplexed pins, with a registered single-pass datapath.
// ----------------------------------------------------------------------------
module charlieplexed_soc_display_driver (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [9:0] soc_tenths, [25:10] current_centiamps, [41:26] fault_flags
    input  logic [csdd_pkg::S_DATA_W-1:0] s_tdata,
    // [0] func
    input  logic                          s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [4:0] pin_enable, [9:5] pin_level, [12:10] phase_shown
    output logic [csdd_pkg::M_DATA_W-1:0] m_tdata
);

    `include "charlieplexed_soc_display_driver_assert.svh"

    localparam int SOC_LO  = 0;
    localparam int CUR_LO  = SOC_LO + csdd_pkg::SOC_W;
    localparam int FLAG_LO = CUR_LO + csdd_pkg::CUR_W;
    localparam int LVL_LO  = csdd_pkg::PIN_W;
    localparam int PH_LO   = 2 * csdd_pkg::PIN_W;
    localparam int M_USED  = PH_LO + csdd_pkg::PHASE_W;

    // input register
    logic                              in_valid_reg;
    logic                              in_func_reg;
    logic [csdd_pkg::SOC_W-1:0]        in_soc_reg;
    logic signed [csdd_pkg::CUR_W-1:0] in_cur_reg;
    logic [csdd_pkg::FLAG_W-1:0]       in_flags_reg;

    // display state
    csdd_pkg::seg_t                    hund_seg_reg, hund_seg_next;
    csdd_pkg::seg_t                    tens_seg_reg, tens_seg_next;
    csdd_pkg::seg_t                    ones_seg_reg, ones_seg_next;
    logic [csdd_pkg::PHASE_W-1:0]      phase_reg, phase_next;

    // result register
    logic                              out_valid_reg;
    logic [csdd_pkg::PIN_W-1:0]        out_en_reg, out_en_next;
    logic [csdd_pkg::PIN_W-1:0]        out_lvl_reg, out_lvl_next;
    logic [csdd_pkg::PHASE_W-1:0]      out_phase_reg;

    logic                              advance;
    logic                              is_tick;
    logic [csdd_pkg::PROD_W-1:0]       soc_prod;
    logic [csdd_pkg::PCT_W-1:0]        pct;
    logic                              pct_hund;
    logic [csdd_pkg::PCT_W-1:0]        pct_rem;
    logic [3:0]                        tens_digit;
    logic [3:0]                        ones_digit;
    logic [csdd_pkg::PIN_W-1:0]        lit;
    logic [csdd_pkg::PIN_W-1:0]        common;

    assign is_tick  = in_func_reg == csdd_pkg::FUNC_TICK;
    // a reading never needs the output side, a tick needs a free result slot
    assign advance  = in_valid_reg && (!is_tick || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // percent = soc_tenths / 10 via reciprocal multiply
    assign soc_prod   = in_soc_reg * csdd_pkg::PROD_W'(csdd_pkg::RECIP_10);
    assign pct        = soc_prod[csdd_pkg::RECIP_SHIFT +: csdd_pkg::PCT_W];
    assign pct_hund   = pct >= csdd_pkg::PCT_W'(100);
    assign pct_rem    = pct_hund ? pct - csdd_pkg::PCT_W'(100) : pct;
    assign tens_digit = csdd_pkg::tens_of(pct_rem);
    assign ones_digit = 4'(pct_rem - csdd_pkg::PCT_W'(tens_digit) * csdd_pkg::PCT_W'(10));

    always_comb begin
        hund_seg_next = hund_seg_reg;
        tens_seg_next = tens_seg_reg;
        ones_seg_next = ones_seg_reg;
        if (advance && !is_tick) begin
            if (in_flags_reg == '0) begin
                hund_seg_next = '0;
                hund_seg_next[csdd_pkg::SEG_A] = 1'b1;
                hund_seg_next[csdd_pkg::SEG_B] = pct_hund;
                hund_seg_next[csdd_pkg::SEG_C] = pct_hund;
                hund_seg_next[csdd_pkg::SEG_D] = in_cur_reg <= csdd_pkg::CHARGE_LIMIT;
                tens_seg_next = csdd_pkg::glyph(tens_digit);
                ones_seg_next = csdd_pkg::glyph(ones_digit);
            end else begin
                hund_seg_next = '0;
                tens_seg_next = csdd_pkg::glyph(csdd_pkg::DIGIT_E);
                ones_seg_next = csdd_pkg::glyph(csdd_pkg::top_flag(in_flags_reg));
            end
        end
    end

    // pin map per phase; bit p is pin p+1
    always_comb begin
        lit    = '0;
        common = '0;
        unique case (phase_reg)
            csdd_pkg::PHASE_0: begin
                common[0] = 1'b1;
                lit[1] = ones_seg_reg[csdd_pkg::SEG_B];
                lit[2] = ones_seg_reg[csdd_pkg::SEG_D];
                lit[3] = ones_seg_reg[csdd_pkg::SEG_F];
                lit[4] = ones_seg_reg[csdd_pkg::SEG_G];
            end
            csdd_pkg::PHASE_1: begin
                common[1] = 1'b1;
                lit[2] = tens_seg_reg[csdd_pkg::SEG_B];
                lit[3] = tens_seg_reg[csdd_pkg::SEG_D];
                lit[4] = tens_seg_reg[csdd_pkg::SEG_E];
                lit[0] = ones_seg_reg[csdd_pkg::SEG_A];
            end
            csdd_pkg::PHASE_2: begin
                common[2] = 1'b1;
                lit[1] = tens_seg_reg[csdd_pkg::SEG_A];
                lit[3] = tens_seg_reg[csdd_pkg::SEG_C];
                lit[4] = tens_seg_reg[csdd_pkg::SEG_F];
                lit[0] = ones_seg_reg[csdd_pkg::SEG_C];
            end
            csdd_pkg::PHASE_3: begin
                common[3] = 1'b1;
                lit[0] = ones_seg_reg[csdd_pkg::SEG_E];
                lit[4] = tens_seg_reg[csdd_pkg::SEG_G];
                lit[2] = hund_seg_reg[csdd_pkg::SEG_B];
                lit[1] = hund_seg_reg[csdd_pkg::SEG_C];
            end
            csdd_pkg::PHASE_4: begin
                common[4] = 1'b1;
                lit[2] = hund_seg_reg[csdd_pkg::SEG_A];
                lit[1] = hund_seg_reg[csdd_pkg::SEG_D];
            end
            default: begin
                common = '0;
            end
        endcase
        out_en_next  = lit | common;
        out_lvl_next = lit;
        phase_next   = (phase_reg < csdd_pkg::PHASE_4) ?
                       phase_reg + csdd_pkg::PHASE_W'(1) : csdd_pkg::PHASE_0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            hund_seg_reg  <= '0;
            tens_seg_reg  <= '0;
            ones_seg_reg  <= '0;
            phase_reg     <= csdd_pkg::PHASE_0;
        end else begin
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end

            hund_seg_reg <= hund_seg_next;
            tens_seg_reg <= tens_seg_next;
            ones_seg_reg <= ones_seg_next;

            if (advance && is_tick) begin
                out_valid_reg <= 1'b1;
                phase_reg     <= phase_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_func_reg  <= s_tuser;
            in_soc_reg   <= s_tdata[SOC_LO +: csdd_pkg::SOC_W];
            in_cur_reg   <= s_tdata[CUR_LO +: csdd_pkg::CUR_W];
            in_flags_reg <= s_tdata[FLAG_LO +: csdd_pkg::FLAG_W];
        end
        if (advance && is_tick) begin
            out_en_reg    <= out_en_next;
            out_lvl_reg   <= out_lvl_next;
            out_phase_reg <= phase_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(csdd_pkg::M_DATA_W - M_USED){1'b0}},
                       out_phase_reg, out_lvl_reg, out_en_reg};

    `CSDD_ASSERT_NOW(a_phase_range, aclk, aresetn, 1'b1, phase_reg <= csdd_pkg::PHASE_4)
    `CSDD_ASSERT_NEXT(a_tick_shows, aclk, aresetn, advance && is_tick, m_tvalid)
    `CSDD_ASSERT_NOW(a_common_low, aclk, aresetn, m_tvalid,
        out_en_reg[out_phase_reg] && !out_lvl_reg[out_phase_reg])
    `CSDD_ASSERT_NOW(a_level_driven, aclk, aresetn, m_tvalid, (out_lvl_reg & ~out_en_reg) == '0)

endmodule
